>>> hdl/lzwc_pkg.sv
package lzwc_pkg;

    localparam int DICT_ENTRIES     = 4096;
    localparam int MAX_OUTPUT_BYTES = 65536;
    localparam int DICT_AW          = $clog2(DICT_ENTRIES);

    localparam int CODE_W = 12;
    localparam int BYTE_W = 8;
    localparam int OFS_W  = 16;
    localparam int LEN_W  = 13;
    localparam int POS_W  = 17;
    localparam int KIND_W = 2;
    localparam int NC_W   = 13;

    localparam logic [NC_W-1:0]   FIRST_FREE_CODE = NC_W'(256);
    localparam logic [NC_W-1:0]   DICT_END        = NC_W'(DICT_ENTRIES);
    localparam logic [CODE_W-1:0] LIT_CODES       = CODE_W'(256);
    localparam logic [LEN_W-1:0]  LEN_MAX         = {LEN_W{1'b1}};
    localparam logic [POS_W-1:0]  LIMIT_MAX       = POS_W'(MAX_OUTPUT_BYTES);

    localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COPY    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd2;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              first;
        logic              is_lit;
    } item_t;

    typedef struct packed {
        logic [OFS_W-1:0] ofs;
        logic [LEN_W-1:0] len;
    } entry_t;

    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
        return (v == LEN_MAX) ? LEN_MAX : v + LEN_W'(1);
    endfunction

    function automatic logic [POS_W-1:0] clip_limit(input logic [POS_W-1:0] v);
        return (v > LIMIT_MAX) ? LIMIT_MAX : v;
    endfunction

endpackage

>>> hdl/lzwc_front.sv
module lzwc_front import lzwc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CODE_W-1:0] s_code,
    input  logic              s_first,
    output logic              q_valid,
    input  logic              q_ready,
    output item_t             q_item
);

    item_t       fifo_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;
    item_t       in_item;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        in_item.code   = s_code;
        in_item.first  = s_first;
        in_item.is_lit = (s_code < LIT_CODES);
        wr_ptr_next    = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next    = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next     = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/lzwc_back.sv
module lzwc_back import lzwc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  item_t             q_item,
    input  logic              cfg_we,
    input  logic [POS_W-1:0]  cfg_wdata,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_kind,
    output logic [BYTE_W-1:0] m_literal_byte,
    output logic [OFS_W-1:0]  m_source_offset,
    output logic [LEN_W-1:0]  m_copy_length,
    output logic [POS_W-1:0]  m_dest_offset,
    output logic              m_block_done
);

    entry_t               dict_mem [DICT_ENTRIES];
    entry_t               rd_data_reg;
    entry_t               fwd_data_reg;
    logic                 fwd_reg;

    logic                 s2_valid_reg;
    item_t                s2_item_reg;

    logic [POS_W-1:0]     limit_reg;
    logic [POS_W-1:0]     remain_reg, remain_next;
    logic [POS_W-1:0]     write_pos_reg, write_pos_next;
    logic [NC_W-1:0]      next_code_reg, next_code_next;
    logic [OFS_W-1:0]     prev_ofs_reg, prev_ofs_next;
    logic [LEN_W-1:0]     prev_len_reg, prev_len_next;
    logic                 done_reg, done_next;

    logic                 m_valid_reg;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [BYTE_W-1:0]    lit_reg, lit_next;
    logic [OFS_W-1:0]     src_reg, src_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [POS_W-1:0]     dest_reg, dest_next;
    logic                 bdone_reg, bdone_next;

    logic                 s2_adv, pop;
    logic [DICT_AW-1:0]   rd_addr;
    logic                 dict_we;
    logic [NC_W-1:0]      wr_code;
    entry_t               wr_data;
    entry_t               entry;
    logic [NC_W-1:0]      code_ext;
    logic [LEN_W-1:0]     want;
    logic [POS_W-1:0]     want_ext, len_full;
    logic                 invalid;
    logic [POS_W-1:0]     cfg_limit;

    assign s2_adv  = s2_valid_reg && (!m_valid_reg || m_ready);
    assign q_ready = !s2_valid_reg || s2_adv;
    assign pop     = q_valid && q_ready;
    assign rd_addr = q_item.code[DICT_AW-1:0];
    assign entry   = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign cfg_limit = clip_limit(cfg_wdata);

    always_comb begin
        code_ext       = {1'b0, s2_item_reg.code};
        remain_next    = remain_reg;
        write_pos_next = write_pos_reg;
        next_code_next = next_code_reg;
        prev_ofs_next  = prev_ofs_reg;
        prev_len_next  = prev_len_reg;
        done_next      = done_reg;
        dict_we        = 1'b0;
        wr_code        = next_code_reg;
        wr_data.ofs    = prev_ofs_reg;
        wr_data.len    = sat_inc(prev_len_reg);
        kind_next      = KIND_IGNORED;
        lit_next       = '0;
        src_next       = '0;
        len_next       = '0;
        dest_next      = write_pos_reg;
        bdone_next     = 1'b0;
        want           = '0;
        invalid        = 1'b0;
        want_ext       = '0;
        len_full       = '0;
        if (s2_item_reg.first) begin
            kind_next      = KIND_LITERAL;
            lit_next       = s2_item_reg.code[BYTE_W-1:0];
            len_next       = LEN_W'(limit_reg != '0);
            dest_next      = '0;
            write_pos_next = POS_W'(len_next);
            remain_next    = limit_reg - POS_W'(len_next);
            next_code_next = FIRST_FREE_CODE;
            prev_ofs_next  = '0;
            prev_len_next  = LEN_W'(1);
            done_next      = (remain_next == '0);
            bdone_next     = done_next;
        end else if (!done_reg) begin
            priority if (s2_item_reg.is_lit) begin
                kind_next = KIND_LITERAL;
                lit_next  = s2_item_reg.code[BYTE_W-1:0];
                want      = LEN_W'(1);
            end else if (code_ext < next_code_reg) begin
                kind_next = KIND_COPY;
                src_next  = entry.ofs;
                want      = entry.len;
            end else if (code_ext == next_code_reg) begin
                kind_next = KIND_COPY;
                src_next  = prev_ofs_reg;
                want      = sat_inc(prev_len_reg);
            end else begin
                kind_next = KIND_INVALID;
                invalid   = 1'b1;
            end
            if (invalid) begin
                done_next  = 1'b1;
                bdone_next = 1'b1;
            end else begin
                want_ext       = POS_W'(want);
                len_full       = (want_ext < remain_reg) ? want_ext : remain_reg;
                len_next       = len_full[LEN_W-1:0];
                write_pos_next = write_pos_reg + len_full;
                remain_next    = remain_reg - len_full;
                if (next_code_reg >= DICT_END) begin
                    done_next = 1'b1;
                end else begin
                    dict_we        = 1'b1;
                    next_code_next = next_code_reg + NC_W'(1);
                end
                prev_ofs_next = write_pos_reg[OFS_W-1:0];
                prev_len_next = len_next;
                if (remain_next == '0) begin
                    done_next = 1'b1;
                end
                bdone_next = done_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv && dict_we) begin
            dict_mem[wr_code[DICT_AW-1:0]] <= wr_data;
        end
        if (pop) begin
            rd_data_reg <= dict_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s2_item_reg  <= q_item;
            fwd_reg      <= s2_adv && dict_we && (wr_code[DICT_AW-1:0] == rd_addr);
            fwd_data_reg <= wr_data;
        end
        if (s2_adv) begin
            kind_reg  <= kind_next;
            lit_reg   <= lit_next;
            src_reg   <= src_next;
            len_reg   <= len_next;
            dest_reg  <= dest_next;
            bdone_reg <= bdone_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            limit_reg     <= '0;
            remain_reg    <= '0;
            write_pos_reg <= '0;
            next_code_reg <= FIRST_FREE_CODE;
            prev_ofs_reg  <= '0;
            prev_len_reg  <= LEN_W'(1);
            done_reg      <= 1'b0;
        end else begin
            if (pop) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_adv) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (s2_adv) begin
                remain_reg    <= remain_next;
                write_pos_reg <= write_pos_next;
                next_code_reg <= next_code_next;
                prev_ofs_reg  <= prev_ofs_next;
                prev_len_reg  <= prev_len_next;
                done_reg      <= done_next;
            end
            if (cfg_we) begin
                limit_reg  <= cfg_limit;
                remain_reg <= (cfg_limit > write_pos_reg) ? cfg_limit - write_pos_reg : '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = kind_reg;
    assign m_literal_byte  = lit_reg;
    assign m_source_offset = src_reg;
    assign m_copy_length   = len_reg;
    assign m_dest_offset   = dest_reg;
    assign m_block_done    = bdone_reg;

    a_invalid_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && kind_reg == KIND_INVALID) |-> bdone_reg)
        else $error("invalid code did not end the block");

    a_next_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_code_reg >= FIRST_FREE_CODE) && (next_code_reg <= DICT_END))
        else $error("next free code out of range");

    a_remain_le_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        remain_reg <= limit_reg)
        else $error("remaining space exceeds output limit");

    a_ignored_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_adv && done_reg && !s2_item_reg.first)
        |=> (kind_reg == KIND_IGNORED) && (len_reg == '0) && !bdone_reg)
        else $error("code after block end not ignored");

    a_literal_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && kind_reg == KIND_LITERAL) |-> (len_reg <= LEN_W'(1)))
        else $error("literal writes more than one byte");

endmodule

>>> hdl/lzw_code_to_copy_command.sv
// Stages: input queue, s2 register with the dictionary read, output register.
// Throughput: one code per cycle unless m_ready stalls the output; the dictionary RAM does one read and
//   one write per cycle, with the entry written by the code just ahead forwarded to the next read.
// Reset: synchronous, active low; clears the input queue pointers and count, the pipeline and
//   output valid flags and the decoder state. Data registers and the dictionary RAM are not cleared.
module lzw_code_to_copy_command import lzwc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CODE_W-1:0] s_code,
    input  logic              s_first,
    input  logic              cfg_we,
    input  logic [POS_W-1:0]  cfg_wdata,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_kind,
    output logic [BYTE_W-1:0] m_literal_byte,
    output logic [OFS_W-1:0]  m_source_offset,
    output logic [LEN_W-1:0]  m_copy_length,
    output logic [POS_W-1:0]  m_dest_offset,
    output logic              m_block_done
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    lzwc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_code  (s_code),
        .s_first (s_first),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    lzwc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_literal_byte  (m_literal_byte),
        .m_source_offset (m_source_offset),
        .m_copy_length   (m_copy_length),
        .m_dest_offset   (m_dest_offset),
        .m_block_done    (m_block_done)
    );

endmodule
